>>> hdl/tdma_flow_slot_scheduler_core_assert.svh
// assertion macros shared by the scheduler checker
`ifndef TDMA_FLOW_SLOT_SCHEDULER_CORE_ASSERT_SVH
`define TDMA_FLOW_SLOT_SCHEDULER_CORE_ASSERT_SVH

// clocked assertion, masked while reset is asserted
`define TFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/tfs_pkg.sv
// shared types and constants of the tdma flow slot scheduler
package tfs_pkg;

  localparam int unsigned MAX_NODES = 16;
  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned NODE_W    = 4;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned FM_AW     = 2 * NODE_W;

  // input kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_SLOT    = 2'd0;
  localparam logic [1:0] ST_NOSLOTS = 2'd1;
  localparam logic [1:0] ST_NOFLOW  = 2'd2;
  localparam logic [1:0] ST_STUCK   = 2'd3;

  // configuration register indexes
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_SLOT_COUNT = 1'b1;

  // flow matrix read port
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             sched;
  } fm_rd_t;

  // flow matrix write and flag control
  typedef struct packed {
    logic             load;
    logic [FM_AW-1:0] load_addr;
    logic [CNT_W-1:0] load_cnt;
    logic             clr_sched;
    logic             set_sched;
    logic [FM_AW-1:0] set_addr;
  } fm_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SUM_RD, S_SUM_EV, S_CHK, S_CLR, S_COL_RD, S_COL_EV, S_SLOT,
    S_PASS_BEGIN, S_ITER, S_ROW_RD, S_ROW_EV, S_LEAF_RD, S_LEAF_EV,
    S_ITER_END, S_PASS_END, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_e;

endpackage

>>> hdl/tfs_flow_mem.sv
// flow matrix store, packet count and scheduled flag per entry, with valid flags
module tfs_flow_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tfs_pkg::fm_ctl_t           ctl_i,
  input  logic [tfs_pkg::FM_AW-1:0]  raddr_i,
  output tfs_pkg::fm_rd_t            rd_o
);
  import tfs_pkg::*;

  localparam int unsigned DEPTH = MAX_NODES * MAX_NODES;

  logic [CNT_W:0]   mem [DEPTH];   // {packets, scheduled}
  logic [DEPTH-1:0] valid_q;
  logic [CNT_W:0]   rd_q;
  logic             rd_vld_q;

  // entries, a flag update rewrites the entry read on the previous cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mem[ctl_i.load_addr] <= {ctl_i.load_cnt, 1'b0};
    end else if (ctl_i.clr_sched || ctl_i.set_sched) begin
      mem[ctl_i.set_addr] <= {rd_q[CNT_W:1], ctl_i.set_sched};
    end
    rd_q <= mem[raddr_i];
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        valid_q[ctl_i.load_addr] <= 1'b1;
      end
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  // entries never loaded read as zero
  assign rd_o.cnt   = rd_vld_q ? rd_q[CNT_W:1] : '0;
  assign rd_o.sched = rd_vld_q && rd_q[0];

endmodule

>>> hdl/tdma_flow_slot_scheduler_core.sv
// tdma convergecast slot scheduler top level
//
//  channel   dir  handshake                       contents
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata from,to,packets; tuser kind
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata status,slot,tx,rx; tlast
//  apb       in   psel/penable/pwrite/pready      node_count at 0, slot_count at 4
//
//  loads may follow back to back
//  a run reads all 256 matrix entries in the sum sweep, which also clears the
//  scheduled flags, then clears the slot table, then reads the matrix on
//  each queue visit and writes one slot table entry per slot granted
//  each result is held until taken on m_axis; no input during a run
//  reset clears control state and the matrix valid flags at once
module tdma_flow_slot_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // from_node[3:0], to_node[7:4], packets[13:8]
  input  logic        s_axis_tuser_i,   // kind[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // status[1:0], slot[7:2], transmitter[11:8],
                                        // receiver[15:12]
  output logic        m_axis_tlast_o,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tfs_pkg::*;

  localparam int unsigned TOT_W = 14;

  state_e state_q, state_d;

  logic [4:0]        node_count_q;
  logic [6:0]        slot_count_q;
  logic [4:0]        n_act;
  logic [6:0]        limit;

  logic [FM_AW-1:0]  a_q, a_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [4:0]        idx_q, idx_d;
  logic [SLOT_W-1:0] k_q, k_d;
  logic [6:0]        slotcur_q, slotcur_d;
  logic [6:0]        before_q, before_d;
  logic [4:0]        len0_q, len0_d, len1_q, len1_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [4:0]        idle_q, idle_d, ipass_q, ipass_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              init_q, init_d;
  logic              outpend_q, outpend_d, parq_q, parq_d, leaf_q, leaf_d;
  logic              erased_q, erased_d;
  logic [NODE_W-1:0] wq_q [MAX_NODES];
  logic [NODE_W-1:0] wq_d [MAX_NODES];
  logic [NODE_W-1:0] nq_q [MAX_NODES];
  logic [NODE_W-1:0] nq_d [MAX_NODES];
  logic [MAX_NODES-1:0] inq_q, inq_d, nqm_q, nqm_d;

  logic [1:0]        o_status_q, o_status_d;
  logic [SLOT_W-1:0] o_slot_q, o_slot_d;
  logic [NODE_W-1:0] o_tx_q, o_tx_d, o_rx_q, o_rx_d;
  logic              o_last_q, o_last_d;

  logic [7:0]        slot_mem [MAX_SLOTS];
  logic [7:0]        st_rd_q;
  logic              st_we;
  logic [SLOT_W-1:0] st_waddr;
  logic [7:0]        st_wdata;

  fm_ctl_t           fm_ctl;
  fm_rd_t            fm_rd;
  logic [FM_AW-1:0]  fm_raddr;
  logic              nz, pend, idx_last, cfg_wr;
  logic [4:0]        nl, idle_n, ipass_n, cur_v;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 5'd16;
      slot_count_q <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NODE_COUNT: node_count_q <= pwdata[4:0];
        REG_SLOT_COUNT: slot_count_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NODE_COUNT: prdata = {27'd0, node_count_q};
      REG_SLOT_COUNT: prdata = {25'd0, slot_count_q};
      default:        prdata = '0;
    endcase
  end

  assign n_act = (node_count_q > 5'(MAX_NODES)) ? 5'(MAX_NODES) : node_count_q;
  assign limit = (slot_count_q > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS) : slot_count_q;

  // flow matrix
  tfs_flow_mem u_fm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fm_ctl),
    .raddr_i (fm_raddr),
    .rd_o    (fm_rd)
  );

  assign nz       = (fm_rd.cnt != '0);
  assign pend     = nz && !fm_rd.sched;
  assign idx_last = ((idx_q + 5'd1) >= n_act);

  // slot table
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      slot_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= slot_mem[k_q];
  end

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len0_q    <= '0;
      len1_q    <= '0;
      cur_q     <= '0;
      slotcur_q <= '0;
      inq_q     <= '0;
      nqm_q     <= '0;
    end else begin
      state_q   <= state_d;
      len0_q    <= len0_d;
      len1_q    <= len1_d;
      cur_q     <= cur_d;
      slotcur_q <= slotcur_d;
      inq_q     <= inq_d;
      nqm_q     <= nqm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    total_q    <= total_d;
    idx_q      <= idx_d;
    k_q        <= k_d;
    before_q   <= before_d;
    node_q     <= node_d;
    idle_q     <= idle_d;
    ipass_q    <= ipass_d;
    rem_q      <= rem_d;
    init_q     <= init_d;
    outpend_q  <= outpend_d;
    parq_q     <= parq_d;
    leaf_q     <= leaf_d;
    erased_q   <= erased_d;
    wq_q       <= wq_d;
    nq_q       <= nq_d;
    o_status_q <= o_status_d;
    o_slot_q   <= o_slot_d;
    o_tx_q     <= o_tx_d;
    o_rx_q     <= o_rx_d;
    o_last_q   <= o_last_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    total_d    = total_q;
    idx_d      = idx_q;
    k_d        = k_q;
    slotcur_d  = slotcur_q;
    before_d   = before_q;
    len0_d     = len0_q;
    len1_d     = len1_q;
    cur_d      = cur_q;
    node_d     = node_q;
    idle_d     = idle_q;
    ipass_d    = ipass_q;
    rem_d      = rem_q;
    init_d     = init_q;
    outpend_d  = outpend_q;
    parq_d     = parq_q;
    leaf_d     = leaf_q;
    erased_d   = erased_q;
    wq_d       = wq_q;
    nq_d       = nq_q;
    inq_d      = inq_q;
    nqm_d      = nqm_q;
    o_status_d = o_status_q;
    o_slot_d   = o_slot_q;
    o_tx_d     = o_tx_q;
    o_rx_d     = o_rx_q;
    o_last_d   = o_last_q;
    fm_ctl     = '0;
    fm_raddr   = a_q;
    st_we      = 1'b0;
    st_waddr   = k_q;
    st_wdata   = '0;
    nl         = len0_q;
    idle_n     = idle_q + 5'd1;
    ipass_n    = ipass_q + 5'd1;
    cur_v      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == KIND_LOAD) begin
            fm_ctl.load      = 1'b1;
            fm_ctl.load_addr = {s_axis_tdata_i[3:0], s_axis_tdata_i[7:4]};
            fm_ctl.load_cnt  = s_axis_tdata_i[13:8];
          end else begin
            total_d          = '0;
            a_d              = '0;
            state_d          = S_SUM_RD;
          end
        end
      end

      // slot total over the active sub-matrix, clearing every scheduled flag
      S_SUM_RD: begin
        fm_raddr = a_q;
        state_d  = S_SUM_EV;
      end
      S_SUM_EV: begin
        fm_ctl.clr_sched = 1'b1;
        fm_ctl.set_addr  = a_q;
        if ((5'(a_q[7:4]) < n_act) && (5'(a_q[3:0]) < n_act)) begin
          total_d = total_q + TOT_W'(fm_rd.cnt);
        end
        a_d     = a_q + 8'd1;
        state_d = (a_q == 8'hFF) ? S_CHK : S_SUM_RD;
      end

      S_CHK: begin
        if (total_q == '0) begin
          o_status_d = ST_NOFLOW;
          o_slot_d   = '0;
          o_tx_d     = '0;
          o_rx_d     = '0;
          o_last_d   = 1'b1;
          state_d    = S_OUT_WAIT;
        end else if (total_q > TOT_W'(limit)) begin
          o_status_d = ST_NOSLOTS;
          o_slot_d   = '0;
          o_tx_d     = '0;
          o_rx_d     = '0;
          o_last_d   = 1'b1;
          state_d    = S_OUT_WAIT;
        end else begin
          slotcur_d = total_q[6:0];
          len0_d    = '0;
          len1_d    = '0;
          inq_d     = '0;
          cur_d     = '0;
          k_d       = '0;
          state_d   = S_CLR;
        end
      end

      // zero the slot table, one entry a cycle
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = k_q;
        st_wdata = '0;
        k_d      = k_q + 6'd1;
        if (k_q == 6'(MAX_SLOTS - 1)) begin
          init_d  = 1'b1;
          node_d  = '0;
          idx_d   = '0;
          ipass_d = '0;
          state_d = S_COL_RD;
        end
      end

      // column pass: links into node_q, queueing and slot assignment
      S_COL_RD: begin
        fm_raddr = {idx_q[3:0], node_q};
        state_d  = S_COL_EV;
      end
      S_COL_EV: begin
        rem_d = fm_rd.sched ? '0 : fm_rd.cnt;
        if (nz) begin
          fm_ctl.set_sched = 1'b1;
          fm_ctl.set_addr  = {idx_q[3:0], node_q};
          if (init_q) begin
            wq_d[len0_q[3:0]]  = idx_q[3:0];
            len0_d             = len0_q + 5'd1;
            inq_d[idx_q[3:0]]  = 1'b1;
          end else if (!nqm_q[idx_q[3:0]] && (len1_q < 5'(MAX_NODES))) begin
            nq_d[len1_q[3:0]]  = idx_q[3:0];
            len1_d             = len1_q + 5'd1;
            nqm_d[idx_q[3:0]]  = 1'b1;
          end
        end
        if (pend) begin
          state_d = S_SLOT;
        end else if (idx_last) begin
          erased_d = 1'b1;
          state_d  = init_q ? S_PASS_BEGIN : S_ITER_END;
        end else begin
          idx_d   = idx_q + 5'd1;
          state_d = S_COL_RD;
        end
      end
      S_SLOT: begin
        if ((rem_q != '0) && (slotcur_q != '0)) begin
          slotcur_d = slotcur_q - 7'd1;
          rem_d     = rem_q - 6'd1;
          st_we     = 1'b1;
          st_waddr  = 6'(slotcur_q - 7'd1);
          st_wdata  = {idx_q[3:0], node_q};
        end else if (idx_last) begin
          erased_d = 1'b1;
          state_d  = init_q ? S_PASS_BEGIN : S_ITER_END;
        end else begin
          idx_d   = idx_q + 5'd1;
          state_d = S_COL_RD;
        end
      end

      // one level of the walk
      S_PASS_BEGIN: begin
        init_d = 1'b0;
        if (len0_q == '0) begin
          k_d     = '0;
          state_d = S_OUT_RD;
        end else begin
          before_d = slotcur_q;
          len1_d   = '0;
          nqm_d    = '0;
          idle_d   = '0;
          state_d  = S_ITER;
        end
      end

      S_ITER: begin
        if (len0_q == '0) begin
          state_d = S_PASS_END;
        end else begin
          cur_d     = (5'(cur_q) >= len0_q) ? '0 : cur_q;
          node_d    = wq_q[(5'(cur_q) >= len0_q) ? '0 : cur_q];
          idx_d     = '0;
          outpend_d = 1'b0;
          parq_d    = 1'b0;
          state_d   = S_ROW_RD;
        end
      end

      // row scan: pending outlinks and queued parents
      S_ROW_RD: begin
        fm_raddr = {node_q, idx_q[3:0]};
        state_d  = S_ROW_EV;
      end
      S_ROW_EV: begin
        if (pend) begin
          outpend_d = 1'b1;
          if (inq_q[idx_q[3:0]]) begin
            parq_d = 1'b1;
          end
        end
        if (idx_last) begin
          idx_d = '0;
          if (!(outpend_q || pend)) begin
            state_d = S_COL_RD;
          end else begin
            leaf_d  = 1'b1;
            state_d = S_LEAF_RD;
          end
        end else begin
          idx_d   = idx_q + 5'd1;
          state_d = S_ROW_RD;
        end
      end

      // leaf test over the column
      S_LEAF_RD: begin
        fm_raddr = {idx_q[3:0], node_q};
        state_d  = S_LEAF_EV;
      end
      S_LEAF_EV: begin
        if (nz) begin
          leaf_d = 1'b0;
        end
        if (idx_last) begin
          erased_d = (leaf_q && !nz) || !parq_q;
          state_d  = S_ITER_END;
        end else begin
          idx_d   = idx_q + 5'd1;
          state_d = S_LEAF_RD;
        end
      end

      // erase or count an idle visit, reporting stuck when every visit is idle, then advance the cursor
      S_ITER_END: begin
        state_d = S_ITER;
        if (erased_q) begin
          nl = len0_q - 5'd1;
          for (int unsigned q = 0; q < MAX_NODES - 1; q++) begin
            if (q >= 32'(cur_q)) begin
              wq_d[q] = wq_q[q+1];
            end
          end
          inq_d[node_q] = 1'b0;
          len0_d        = nl;
          idle_d        = '0;
        end else begin
          idle_d = idle_n;
          if (idle_n >= len0_q) begin
            o_status_d = ST_STUCK;
            o_slot_d   = '0;
            o_tx_d     = '0;
            o_rx_d     = '0;
            o_last_d   = 1'b1;
            state_d    = S_OUT_WAIT;
          end
        end
        if (nl == 5'd1) begin
          cur_d = '0;
        end else if (nl != '0) begin
          cur_v = 5'(cur_q) + 5'd1;
          if (cur_v >= nl) begin
            cur_v = cur_v - nl;
          end
          cur_d = cur_v[3:0];
        end
      end

      S_PASS_END: begin
        wq_d    = nq_q;
        len0_d  = len1_q;
        inq_d   = nqm_q;
        cur_d   = '0;
        state_d = S_PASS_BEGIN;
        if ((slotcur_q == before_q) && (len1_q != '0)) begin
          ipass_d = ipass_n;
          if (ipass_n >= n_act) begin
            o_status_d = ST_STUCK;
            o_slot_d   = '0;
            o_tx_d     = '0;
            o_rx_d     = '0;
            o_last_d   = 1'b1;
            state_d    = S_OUT_WAIT;
          end
        end else begin
          ipass_d = '0;
        end
      end

      // results in slot order
      S_OUT_RD: begin
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        o_status_d = ST_SLOT;
        o_slot_d   = k_q;
        o_tx_d     = st_rd_q[7:4];
        o_rx_d     = st_rd_q[3:0];
        o_last_d   = ((TOT_W'(k_q) + TOT_W'(1)) == total_q);
        state_d    = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (m_axis_tready_i) begin
          if (o_last_q) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 6'd1;
            state_d = S_OUT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // stream ports
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT_WAIT);
  assign m_axis_tdata_o  = {o_rx_q, o_tx_q, o_slot_q, o_status_q};
  assign m_axis_tlast_o  = o_last_q;

endmodule

>>> hdl/tfs_checker.sv
// port-level checks of the slot scheduler, bound to the top level
`include "tdma_flow_slot_scheduler_core_assert.svh"

module tfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic        m_axis_tlast_o
);
  // never takes an item while a result is offered
  `TFS_ASSERT(a_no_overlap, clk_i, rst_ni, !(s_axis_tready_o && m_axis_tvalid_o), "input ready while result valid")
  // a result is held until taken
  `TFS_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o, "result dropped")
  // the final result of a run frees the input
  `TFS_ASSERT(a_last_idle, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o, "not ready after last")
  // a load transaction keeps the input open
  `TFS_ASSERT(a_load_open, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i) |=> s_axis_tready_o, "load blocked input")
endmodule

bind tdma_flow_slot_scheduler_core tfs_checker u_tfs_checker (.*);

>>> tb/tb_tdma_flow_slot_scheduler_core.sv
// self-checking testbench for the convergecast tdma slot scheduler core
module tb_tdma_flow_slot_scheduler_core;
  import tfs_pkg::*;

  localparam int QUIET_LIMIT = 100000;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic       kind;
    logic [3:0] from_node;
    logic [3:0] to_node;
    logic [5:0] packets;
  } flow_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot;
    logic [3:0] transmitter;
    logic [3:0] receiver;
    logic       last;
  } slot_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tdma_flow_slot_scheduler_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  flow_item_t  pending_items[$];
  slot_entry_t slot_expect[$];
  int          items_in = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          quiet = 0;
  bit          in_fire = 1'b0;
  bit          live[256];

  // predictor state
  logic [4:0] cfg_nodes = 5'd16;
  logic [6:0] cfg_slots = 7'd64;
  logic [5:0] fm_cnt[256];
  bit         fm_done[256];
  int         wq[16], nq[16];
  int         wlen, nlen, cur, slot_cur, active;
  logic [3:0] tbl_tx[64], tbl_rx[64];

  function automatic bit fm_nz(int i, int j);
    return fm_cnt[i*16+j] != 0 || fm_done[i*16+j];
  endfunction

  function automatic bit link_pending(int i, int j);
    return fm_cnt[i*16+j] != 0 && !fm_done[i*16+j];
  endfunction

  function automatic void sched_link(int s, int d);
    int w = link_pending(s, d) ? int'(fm_cnt[s*16+d]) : 0;
    for (int k = 0; k < w && slot_cur > 0; k++) begin
      slot_cur--;
      tbl_tx[slot_cur] = s[3:0];
      tbl_rx[slot_cur] = d[3:0];
    end
    fm_done[s*16+d] = 1'b1;
  endfunction

  function automatic void drop_current();
    for (int m = cur; m + 1 < wlen; m++) wq[m] = wq[m+1];
    wlen--;
  endfunction

  // level-by-level walk outward from the sink, returns 1 when stuck
  function automatic bit walk_stuck();
    int  idle_passes = 0;
    int  base_slot, idle, node;
    bit  erased, leaf, busy, blocked, dup;
    while (wlen > 0) begin
      base_slot = slot_cur;
      idle = 0;
      nlen = 0;
      while (wlen > 0) begin
        if (cur >= wlen) cur = 0;
        node = wq[cur];
        erased = 1'b1;
        leaf = 1'b1;
        for (int i = 0; i < active; i++) if (fm_nz(i, node)) leaf = 1'b0;
        if (leaf) begin
          drop_current();
        end else begin
          busy = 1'b0;
          for (int j = 0; j < active; j++) if (link_pending(node, j)) busy = 1'b1;
          if (!busy) begin
            for (int i = 0; i < active; i++) begin
              if (fm_nz(i, node)) begin
                dup = 1'b0;
                for (int k = 0; k < nlen; k++) if (nq[k] == i) dup = 1'b1;
                if (!dup && nlen < 16) nq[nlen++] = i;
                sched_link(i, node);
              end
            end
            drop_current();
          end else begin
            blocked = 1'b0;
            for (int j = 0; j < active; j++)
              if (link_pending(node, j))
                for (int k = 0; k < wlen; k++) if (wq[k] == j) blocked = 1'b1;
            if (!blocked) drop_current();
            else erased = 1'b0;
          end
        end
        if (erased) begin
          idle = 0;
        end else begin
          idle++;
          if (idle >= wlen) return 1'b1;
        end
        if (wlen > 0) cur = (cur + 1) % wlen;
      end
      wq = nq;
      wlen = nlen;
      cur = 0;
      if (slot_cur == base_slot && wlen > 0) begin
        idle_passes++;
        if (idle_passes >= active) return 1'b1;
      end else begin
        idle_passes = 0;
      end
    end
    return 1'b0;
  endfunction

  // work out the slot entries that one accepted transaction causes
  function automatic void predict_schedule(flow_item_t it);
    int total = 0;
    int limit;
    slot_entry_t e;
    if (it.kind == KIND_LOAD) begin
      fm_cnt[it.from_node*16+it.to_node] = it.packets;
      fm_done[it.from_node*16+it.to_node] = 1'b0;
      return;
    end
    active = cfg_nodes > 16 ? 16 : int'(cfg_nodes);
    foreach (fm_done[k]) fm_done[k] = 1'b0;
    for (int i = 0; i < active; i++)
      for (int j = 0; j < active; j++) total += fm_cnt[i*16+j];
    limit = cfg_slots > 64 ? 64 : int'(cfg_slots);
    e = '0;
    e.last = 1'b1;
    if (total == 0) begin
      e.status = ST_NOFLOW;
      slot_expect = {slot_expect, e};
      return;
    end
    if (total > limit) begin
      e.status = ST_NOSLOTS;
      slot_expect = {slot_expect, e};
      return;
    end
    foreach (tbl_tx[k]) begin
      tbl_tx[k] = '0;
      tbl_rx[k] = '0;
    end
    slot_cur = total;
    wlen = 0;
    nlen = 0;
    cur = 0;
    for (int i = 0; i < active; i++) if (fm_nz(i, 0)) wq[wlen++] = i;
    for (int k = 0; k < wlen; k++) sched_link(wq[k], 0);
    if (walk_stuck()) begin
      e.status = ST_STUCK;
      slot_expect = {slot_expect, e};
      return;
    end
    for (int k = 0; k < total; k++) begin
      e.status = ST_SLOT;
      e.slot = k[5:0];
      e.transmitter = tbl_tx[k];
      e.receiver = tbl_rx[k];
      e.last = (k + 1 == total);
      slot_expect = {slot_expect, e};
    end
  endfunction

  // input side: present queued transactions with random gaps
  always @(negedge clk_i) begin
    bit offer;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_fire) begin
      offer = pending_items.size() > 0 &&
              ((items_in >= 70 && items_in < 110) || $urandom_range(0, 99) >= 34);
      if (offer) begin
        s_tdata <= {2'b00, pending_items[0].packets, pending_items[0].to_node,
                    pending_items[0].from_node};
        s_tuser <= pending_items[0].kind;
        void'(pending_items.pop_front());
      end
      s_valid <= offer;
    end
  end

  // output side: random stalls plus one long hold-off
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 20) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_ready <= 1'b0;
    end else begin
      m_ready <= (results_seen >= 30 && results_seen < 70) ||
                 $urandom_range(0, 99) >= 34;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    slot_entry_t got, want;
    flow_item_t  it;
    in_fire <= s_valid && s_ready;
    if (rst_ni) begin
      quiet++;
      if (s_valid && s_ready) begin
        quiet = 0;
        items_in++;
        it = {s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[13:8]};
        predict_schedule(it);
      end
      if (m_valid && m_ready) begin
        quiet = 0;
        results_seen++;
        got = {m_tdata[1:0], m_tdata[7:2], m_tdata[11:8], m_tdata[15:12], m_tlast};
        if (slot_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = slot_expect.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: want st=%0d slot=%0d tx=%0d rx=%0d last=%0d,",
                        " got st=%0d slot=%0d tx=%0d rx=%0d last=%0d"},
                       want.status, want.slot, want.transmitter, want.receiver,
                       want.last, got.status, got.slot, got.transmitter,
                       got.receiver, got.last);
          end
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_tdma_flow_slot_scheduler_core: errors");
        $finish;
      end
    end
  end

  function automatic void add_load(int f, int t, int p);
    flow_item_t it;
    it.kind = KIND_LOAD;
    it.from_node = f[3:0];
    it.to_node = t[3:0];
    it.packets = p[5:0];
    live[f*16+t] = (p != 0);
    pending_items = {pending_items, it};
  endfunction

  function automatic void add_run();
    flow_item_t it = '0;
    it.kind = KIND_RUN;
    it.from_node = $urandom_range(0, 15);
    it.to_node = $urandom_range(0, 15);
    it.packets = $urandom_range(0, 63);
    pending_items = {pending_items, it};
  endfunction

  function automatic void clear_links();
    foreach (live[k]) if (live[k]) add_load(k / 16, k % 16, 0);
  endfunction

  // wait for the block to drain and settle before touching registers
  task automatic drain();
    while (pending_items.size() > 0 || s_valid || slot_expect.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(logic regsel, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regsel == REG_NODE_COUNT) cfg_nodes = value[4:0];
    else cfg_slots = value[6:0];
  endtask

  // random tree toward the sink, sometimes over budget or with noise
  task automatic random_tree(int nodes, int budget);
    int parent, pk;
    clear_links();
    if ($urandom_range(0, 5) == 0) budget += 12;
    for (int n = 1; n < nodes && budget > 0; n++) begin
      parent = $urandom_range(0, n - 1);
      pk = $urandom_range(1, 3);
      if (pk > budget) pk = budget;
      budget -= pk;
      add_load(n, parent, pk);
    end
    if ($urandom_range(0, 3) == 0)
      add_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 63));
    add_run();
    if ($urandom_range(0, 7) == 0) add_run();
  endtask

  initial begin
    int nodes_cfg[5] = '{2, 16, 6, 31, 9};
    int slots_cfg[5] = '{1, 64, 24, 127, 40};
    int act, lim, nmax, start;
    foreach (fm_cnt[k]) begin
      fm_cnt[k] = '0;
      fm_done[k] = 1'b0;
      live[k] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty matrix, full-size link, over limit, exact fit
    add_run();
    add_load(1, 0, 63);
    add_run();
    add_load(2, 0, 2);
    add_run();
    add_load(2, 0, 1);
    add_run();
    add_load(15, 15, 63);
    add_run();
    // mutual links between two queued nodes stall the queue
    add_load(15, 15, 0);
    add_load(1, 0, 1);
    add_load(2, 0, 1);
    add_load(1, 2, 1);
    add_load(2, 1, 1);
    add_run();
    // links never reached from the sink stay empty
    add_load(1, 2, 0);
    add_load(2, 1, 0);
    add_load(3, 4, 2);
    add_run();
    drain();

    // random phases over several register settings
    for (int p = 0; p < 5; p++) begin
      apb_write(REG_NODE_COUNT, nodes_cfg[p]);
      apb_write(REG_SLOT_COUNT, slots_cfg[p]);
      act = nodes_cfg[p] > 16 ? 16 : nodes_cfg[p];
      lim = slots_cfg[p] > 64 ? 64 : slots_cfg[p];
      start = items_in + pending_items.size();
      while (items_in + pending_items.size() - start < 27) begin
        nmax = ($urandom_range(0, 4) == 0) ? act : (act < 6 ? act : 6);
        random_tree($urandom_range(2, nmax), lim);
      end
      drain();
    end

    if (slot_expect.size() == 0 && mismatches == 0) begin
      $display("tb_tdma_flow_slot_scheduler_core: clean");
    end else begin
      $display("tb_tdma_flow_slot_scheduler_core: errors");
    end
    $finish;
  end

endmodule
